>>> rtl/core/ted_pkg.sv
`default_nettype none
package ted_pkg;

    localparam int unsigned MaxSampleBytes = 65536;
    localparam int unsigned CountW = $clog2(MaxSampleBytes + 1);

    typedef enum logic [2:0] {
        ENC_UTF8    = 3'd0,
        ENC_UTF16LE = 3'd1,
        ENC_UTF16BE = 3'd2,
        ENC_GB18030 = 3'd3,
        ENC_BIG5    = 3'd4
    } enc_t;

    typedef enum logic [2:0] {
        RULE_ANY  = 3'd0,
        RULE_A0BF = 3'd1,
        RULE_809F = 3'd2,
        RULE_90BF = 3'd3,
        RULE_808F = 3'd4
    } rule_t;

    // accumulated per-sample statistics
    typedef struct packed {
        logic [CountW-1:0] byte_count;
        logic [23:0]       head_bytes;
        logic              prev_zero;
        logic [15:0]       even_zero;
        logic [15:0]       odd_zero;
        logic [1:0]        u8_remaining;
        rule_t             u8_rule;
        logic              u8_range_bad;
        logic              u8_failed;
        logic [1:0]        gb_phase;
        logic [7:0]        gb_lead;
        logic              gb_valid;
        logic [15:0]       gb_pairs;
        logic [15:0]       gb_hits;
        logic              b5_pending;
        logic [7:0]        b5_lead;
        logic              b5_valid;
        logic [15:0]       b5_pairs;
        logic [15:0]       b5_hits;
    } stats_t;

    function automatic stats_t stats_clear();
        stats_t s;
        s = '0;
        s.gb_valid = 1'b1;
        s.b5_valid = 1'b1;
        return s;
    endfunction

    function automatic logic [15:0] sat_inc(input logic [15:0] v);
        return (v != 16'hFFFF) ? v + 16'd1 : v;
    endfunction

    function automatic logic gb_rom_has(input logic [15:0] k);
        case (k)
            16'h81ED, 16'h8283, 16'h87F8, 16'h8C57, 16'h8CA6, 16'h9572, 16'h95F8,
            16'h95FE, 16'h9EB3, 16'h9EE9, 16'h9F6F, 16'hAC46, 16'hB06C, 16'hB1BE,
            16'hB2BB, 16'hB3A4, 16'hB3C9, 16'hB3F6, 16'hB4CB, 16'hB4CE, 16'hB4F3,
            16'hB5BD, 16'hB5C0, 16'hB5C3, 16'hB5C4, 16'hB5D8, 16'hB5DA, 16'hB6C1,
            16'hB6D4, 16'hB6E0, 16'hB6F8, 16'hB6FE, 16'hB7A2, 16'hB8DF, 16'hB8F6,
            16'hB9FA, 16'hB9FD, 16'hBAC3, 16'hBAF3, 16'hBBB9, 16'hBBE1, 16'hBCD2,
            16'hBDF8, 16'hBE57, 16'hBECD, 16'hBFAA, 16'hBFB4, 16'hC0B4, 16'hC0EF,
            16'hC1CB, 16'hC295, 16'hC3C7, 16'hC3E6, 16'hC3F7, 16'hC4DC, 16'hC4E3,
            16'hC4EA, 16'hC55F, 16'hC563, 16'hC6F0, 16'hC7B0, 16'hC8A5, 16'hC8BB,
            16'hC8CB, 16'hC8D5, 16'hC8FD, 16'hC9CF, 16'hC9F9, 16'hC9FA, 16'hCAB1,
            16'hCAC2, 16'hCAC7, 16'hCAD6, 16'hCAE9, 16'hCBB5, 16'hCBFB, 16'hCBFD,
            16'hCCA8, 16'hCCE5, 16'hCCEC, 16'hCDE5, 16'hCDF8, 16'hCEAA, 16'hCEC4,
            16'hCED2, 16'hCEDE, 16'hCFC2, 16'hCFD6, 16'hCFEB, 16'hD0A1, 16'hD0C4,
            16'hD0D0, 16'hD165, 16'hD1A7, 16'hD2B2, 16'hD2BB, 16'hD2D1, 16'hD3C3,
            16'hD3D0, 16'hD3DA, 16'hD3EB, 16'hD4C2, 16'hD4DA, 16'hD566, 16'hD5C2,
            16'hD5E2, 16'hD6BB, 16'hD6D0, 16'hD6F8, 16'hD778, 16'hD7C5, 16'hD7D3,
            16'hD7EE, 16'hDF40, 16'hDF4D, 16'hDF5E, 16'hDF80, 16'hE1E1, 16'hE94C,
            16'hE95F, 16'hECB6, 16'hF377: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic logic b5_rom_has(input logic [15:0] k);
        case (k)
            16'hA440, 16'hA446, 16'hA447, 16'hA448, 16'hA454, 16'hA455, 16'hA457,
            16'hA45D, 16'hA45F, 16'hA46A, 16'hA46C, 16'hA470, 16'hA477, 16'hA4A3,
            16'hA4A4, 16'hA4D1, 16'hA4DF, 16'hA4E2, 16'hA4E5, 16'hA4E9, 16'hA4EB,
            16'hA54C, 16'hA558, 16'hA568, 16'hA575, 16'hA578, 16'hA5BB, 16'hA5CD,
            16'hA5CE, 16'hA65A, 16'hA661, 16'hA662, 16'hA668, 16'hA66E, 16'hA66F,
            16'hA67E, 16'hA6A8, 16'hA6B3, 16'hA6B8, 16'hA6B9, 16'hA6D3, 16'hA6E6,
            16'hA741, 16'hA7DA, 16'hA8BD, 16'hA8C6, 16'hA8D3, 16'hA8EC, 16'hA9F3,
            16'hA9FA, 16'hAABA, 16'hAAF8, 16'hAB65, 16'hABE1, 16'hAC4F, 16'hACB0,
            16'hACDD, 16'hADB1, 16'hADCC, 16'hAE61, 16'hAEC9, 16'hAED1, 16'hAFE0,
            16'hB05F, 16'hB0AA, 16'hB0EA, 16'hB16F, 16'hB27B, 16'hB2C4, 16'hB36F,
            16'hB3B9, 16'hB3CC, 16'hB44E, 16'hB54C, 16'hB54D, 16'hB56F, 16'hB5DB,
            16'hB669, 16'hB67D, 16'hB751, 16'hB77C, 16'hB8CC, 16'hB944, 16'hB94C,
            16'hB9EF, 16'hBAF4, 16'hBB4F, 16'hBB50, 16'hBBA1, 16'hBEC7, 16'hC16E,
            16'hC1D9, 16'hC5AA, 16'hC5E9, 16'hC657, 16'hC94F, 16'hCA49,
            16'hCA5E: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

endpackage
`default_nettype wire

>>> rtl/core/ted_update.sv
`default_nettype none
module ted_update
    import ted_pkg::*;
(
    input  wire stats_t     cur,
    input  wire logic [7:0] b,
    output stats_t          nxt
);

    logic cont;
    logic gb_trail;
    logic b5_trail;
    logic n_odd;

    assign cont     = (b[7:6] == 2'b10);
    assign gb_trail = (b >= 8'h40 && b <= 8'h7E) || (b >= 8'h80 && b <= 8'hFE);
    assign b5_trail = (b >= 8'h40 && b <= 8'h7E) || (b >= 8'hA1 && b <= 8'hFE);
    assign n_odd    = cur.byte_count[0];

    always_comb begin
        nxt = cur;
        if (cur.byte_count < CountW'(MaxSampleBytes)) begin
            nxt.byte_count = cur.byte_count + CountW'(1);
            if (cur.byte_count == CountW'(0)) nxt.head_bytes[23:16] = b;
            if (cur.byte_count == CountW'(1)) nxt.head_bytes[15:8] = b;
            if (cur.byte_count == CountW'(2)) nxt.head_bytes[7:0] = b;
            if (!n_odd) begin
                nxt.prev_zero = (b == 8'h00);
            end else begin
                if (cur.prev_zero) nxt.even_zero = sat_inc(cur.even_zero);
                if (b == 8'h00) nxt.odd_zero = sat_inc(cur.odd_zero);
            end

            // utf-8 validation
            if (!cur.u8_failed) begin
                if (cur.u8_remaining == 2'd0) begin
                    nxt.u8_range_bad = 1'b0;
                    nxt.u8_rule = RULE_ANY;
                    if (b <= 8'h7F) begin
                        nxt.u8_remaining = 2'd0;
                    end else if (b >= 8'hC2 && b <= 8'hDF) begin
                        nxt.u8_remaining = 2'd1;
                    end else if (b == 8'hE0) begin
                        nxt.u8_remaining = 2'd2; nxt.u8_rule = RULE_A0BF;
                    end else if (b == 8'hED) begin
                        nxt.u8_remaining = 2'd2; nxt.u8_rule = RULE_809F;
                    end else if (b >= 8'hE1 && b <= 8'hEF) begin
                        nxt.u8_remaining = 2'd2;
                    end else if (b == 8'hF0) begin
                        nxt.u8_remaining = 2'd3; nxt.u8_rule = RULE_90BF;
                    end else if (b == 8'hF4) begin
                        nxt.u8_remaining = 2'd3; nxt.u8_rule = RULE_808F;
                    end else if (b >= 8'hF1 && b <= 8'hF3) begin
                        nxt.u8_remaining = 2'd3;
                    end else begin
                        nxt.u8_failed = 1'b1;
                    end
                end else if (!cont) begin
                    nxt.u8_failed = 1'b1;
                end else begin
                    if ((cur.u8_rule == RULE_A0BF && b < 8'hA0) ||
                        (cur.u8_rule == RULE_809F && b > 8'h9F) ||
                        (cur.u8_rule == RULE_90BF && b < 8'h90) ||
                        (cur.u8_rule == RULE_808F && b > 8'h8F))
                        nxt.u8_range_bad = 1'b1;
                    nxt.u8_rule = RULE_ANY;
                    nxt.u8_remaining = cur.u8_remaining - 2'd1;
                    if (cur.u8_remaining == 2'd1 && nxt.u8_range_bad) nxt.u8_failed = 1'b1;
                end
            end

            // gb18030 scorer
            if (cur.gb_valid) begin
                case (cur.gb_phase)
                    2'd0: begin
                        if (b > 8'h7F) begin
                            if (b < 8'h81 || b > 8'hFE) begin
                                nxt.gb_valid = 1'b0;
                            end else begin
                                nxt.gb_lead = b; nxt.gb_phase = 2'd1;
                            end
                        end
                    end
                    2'd1: begin
                        if (b >= 8'h30 && b <= 8'h39) begin
                            nxt.gb_phase = 2'd2;
                        end else if (!gb_trail) begin
                            nxt.gb_valid = 1'b0;
                        end else begin
                            if (gb_rom_has({cur.gb_lead, b})) nxt.gb_hits = sat_inc(cur.gb_hits);
                            nxt.gb_pairs = sat_inc(cur.gb_pairs);
                            nxt.gb_phase = 2'd0;
                        end
                    end
                    2'd2: begin
                        nxt.gb_lead = {7'd0, (b >= 8'h81 && b <= 8'hFE)};
                        nxt.gb_phase = 2'd3;
                    end
                    default: begin
                        if (cur.gb_lead == 8'd0 || b < 8'h30 || b > 8'h39) begin
                            nxt.gb_valid = 1'b0;
                        end else begin
                            nxt.gb_pairs = sat_inc(cur.gb_pairs);
                            nxt.gb_phase = 2'd0;
                        end
                    end
                endcase
            end

            // big5 scorer
            if (cur.b5_valid) begin
                if (!cur.b5_pending) begin
                    if (b > 8'h7F) begin
                        if (b < 8'h81 || b > 8'hFE) begin
                            nxt.b5_valid = 1'b0;
                        end else begin
                            nxt.b5_lead = b; nxt.b5_pending = 1'b1;
                        end
                    end
                end else if (!b5_trail) begin
                    nxt.b5_valid = 1'b0;
                end else begin
                    if (b5_rom_has({cur.b5_lead, b})) nxt.b5_hits = sat_inc(cur.b5_hits);
                    nxt.b5_pairs = sat_inc(cur.b5_pairs);
                    nxt.b5_pending = 1'b0;
                end
            end
        end
    end

endmodule
`default_nettype wire

>>> rtl/core/ted_decide.sv
`default_nettype none
module ted_decide
    import ted_pkg::*;
(
    input  wire stats_t s,
    input  wire logic   trunc,
    output enc_t        enc
);

    logic [CountW-2:0] pairs;
    logic [18:0]       od5, ev5;
    logic [20:0]       od20, ev20;
    logic [15:0]       pmin;
    logic [29:0]       m3prod;
    logic [15:0]       m12;
    logic [15:0]       m;
    logic [16:0]       gb_lim;
    logic              gv, bv, long_enough;

    assign pairs = s.byte_count[CountW-1:1];
    assign od5   = {3'd0, s.odd_zero} * 19'd5;
    assign ev5   = {3'd0, s.even_zero} * 19'd5;
    assign od20  = {5'd0, s.odd_zero} * 21'd20;
    assign ev20  = {5'd0, s.even_zero} * 21'd20;
    assign pmin  = (s.gb_pairs < s.b5_pairs) ? s.gb_pairs : s.b5_pairs;
    // divide by 12: drop two bits, then divide by 3 via reciprocal multiply
    assign m3prod = {16'd0, pmin[15:2]} * 30'd43691;
    assign m12   = {3'd0, m3prod[29:17]};
    assign m     = (m12 < 16'd2) ? 16'd2 : m12;
    assign gb_lim = {1'b0, s.gb_hits} + {1'b0, m};
    assign gv    = s.gb_valid && (s.gb_phase == 2'd0 || trunc);
    assign bv    = s.b5_valid && (!s.b5_pending || trunc);
    assign long_enough = s.byte_count >= CountW'(8);

    always_comb begin
        if (s.byte_count >= CountW'(3) && s.head_bytes == 24'hEFBBBF) begin
            enc = ENC_UTF8;
        end else if (s.byte_count >= CountW'(2) && s.head_bytes[23:8] == 16'hFFFE) begin
            enc = ENC_UTF16LE;
        end else if (s.byte_count >= CountW'(2) && s.head_bytes[23:8] == 16'hFEFF) begin
            enc = ENC_UTF16BE;
        end else if (long_enough && 32'(od5) > 32'(pairs) && 32'(ev20) < 32'(pairs)) begin
            enc = ENC_UTF16LE;
        end else if (long_enough && 32'(ev5) > 32'(pairs) && 32'(od20) < 32'(pairs)) begin
            enc = ENC_UTF16BE;
        end else if (!s.u8_failed && (s.u8_remaining == 2'd0 || trunc)) begin
            enc = ENC_UTF8;
        end else if (bv && !gv) begin
            enc = ENC_BIG5;
        end else if (gv && bv && s.b5_hits >= 16'd2 && {1'b0, s.b5_hits} >= gb_lim) begin
            enc = ENC_BIG5;
        end else begin
            enc = ENC_GB18030;
        end
    end

endmodule
`default_nettype wire

>>> rtl/core/text_encoding_detector.sv
`default_nettype none
// one byte accepted per cycle unless input is stalled; statistics update from the input register
// result is registered: the last beat passes the input register, then the result register
// a held result stalls input only when a second result would have to be queued
// synchronous active-low reset clears the sample statistics, sample_truncated and both valids
module text_encoding_detector
    import ted_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [7:0] cfg_data,      // [0] sample_truncated
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,       // [7:0] byte_value
    input  wire logic       s_tlast,       // last_byte
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata        // [2:0] encoding
);

    logic       trunc_reg;
    logic       in_vld_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    stats_t     st_reg, st_next, st_upd;
    logic       out_vld_reg;
    enc_t       out_enc_reg;
    enc_t       dec_enc;
    logic       stall;

    ted_update u_upd (.cur(st_reg), .b(in_byte_reg), .nxt(st_upd));
    ted_decide u_dec (.s(st_upd), .trunc(trunc_reg), .enc(dec_enc));

    // stage holds only if it carries a last beat and the result slot is busy
    assign stall     = in_vld_reg && in_last_reg && out_vld_reg && !m_tready;
    assign s_tready  = !stall;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_vld_reg;
    assign m_tdata   = {5'd0, out_enc_reg};

    always_comb begin
        st_next = st_reg;
        if (in_vld_reg && !stall) st_next = in_last_reg ? stats_clear() : st_upd;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            trunc_reg   <= 1'b0;
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            st_reg      <= stats_clear();
        end else begin
            if (cfg_valid) trunc_reg <= cfg_data[0];
            st_reg <= st_next;
            if (!stall) begin
                in_vld_reg  <= s_tvalid;
                in_byte_reg <= s_tdata;
                in_last_reg <= s_tlast;
            end
            if (in_vld_reg && in_last_reg && !stall) begin
                out_vld_reg <= 1'b1;
                out_enc_reg <= dec_enc;
            end else if (m_tready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn) stall |=> $stable(st_reg))
        else $error("stats changed while stalled");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_vld_reg && in_last_reg && !stall) |=> (m_tvalid && st_reg == stats_clear()))
        else $error("last beat did not produce a result and clear");
    assert property (@(posedge aclk) disable iff (!aresetn) (m_tvalid && !m_tready) |=> m_tvalid)
        else $error("result dropped");
    assert property (@(posedge aclk) disable iff (!aresetn) m_tvalid |-> m_tdata[2:0] <= 3'd4)
        else $error("bad encoding code");

endmodule
`default_nettype wire

>>> dv/text_encoding_detector_tb.sv
`timescale 1ns / 100ps
module text_encoding_detector_tb;
    import ted_pkg::*;

    localparam int unsigned IdleLimit = 4000;
    localparam int unsigned RandomBytes = 290;
    localparam int unsigned SettleCycles = 6;

    localparam logic [15:0] GB_COMMON [122] = '{
        16'h81ED, 16'h8283, 16'h87F8, 16'h8C57, 16'h8CA6, 16'h9572, 16'h95F8, 16'h95FE,
        16'h9EB3, 16'h9EE9, 16'h9F6F, 16'hAC46, 16'hB06C, 16'hB1BE, 16'hB2BB, 16'hB3A4,
        16'hB3C9, 16'hB3F6, 16'hB4CB, 16'hB4CE, 16'hB4F3, 16'hB5BD, 16'hB5C0, 16'hB5C3,
        16'hB5C4, 16'hB5D8, 16'hB5DA, 16'hB6C1, 16'hB6D4, 16'hB6E0, 16'hB6F8, 16'hB6FE,
        16'hB7A2, 16'hB8DF, 16'hB8F6, 16'hB9FA, 16'hB9FD, 16'hBAC3, 16'hBAF3, 16'hBBB9,
        16'hBBE1, 16'hBCD2, 16'hBDF8, 16'hBE57, 16'hBECD, 16'hBFAA, 16'hBFB4, 16'hC0B4,
        16'hC0EF, 16'hC1CB, 16'hC295, 16'hC3C7, 16'hC3E6, 16'hC3F7, 16'hC4DC, 16'hC4E3,
        16'hC4EA, 16'hC55F, 16'hC563, 16'hC6F0, 16'hC7B0, 16'hC8A5, 16'hC8BB, 16'hC8CB,
        16'hC8D5, 16'hC8FD, 16'hC9CF, 16'hC9F9, 16'hC9FA, 16'hCAB1, 16'hCAC2, 16'hCAC7,
        16'hCAD6, 16'hCAE9, 16'hCBB5, 16'hCBFB, 16'hCBFD, 16'hCCA8, 16'hCCE5, 16'hCCEC,
        16'hCDE5, 16'hCDF8, 16'hCEAA, 16'hCEC4, 16'hCED2, 16'hCEDE, 16'hCFC2, 16'hCFD6,
        16'hCFEB, 16'hD0A1, 16'hD0C4, 16'hD0D0, 16'hD165, 16'hD1A7, 16'hD2B2, 16'hD2BB,
        16'hD2D1, 16'hD3C3, 16'hD3D0, 16'hD3DA, 16'hD3EB, 16'hD4C2, 16'hD4DA, 16'hD566,
        16'hD5C2, 16'hD5E2, 16'hD6BB, 16'hD6D0, 16'hD6F8, 16'hD778, 16'hD7C5, 16'hD7D3,
        16'hD7EE, 16'hDF40, 16'hDF4D, 16'hDF5E, 16'hDF80, 16'hE1E1, 16'hE94C, 16'hE95F,
        16'hECB6, 16'hF377
    };
    localparam logic [15:0] B5_COMMON [98] = '{
        16'hA440, 16'hA446, 16'hA447, 16'hA448, 16'hA454, 16'hA455, 16'hA457, 16'hA45D,
        16'hA45F, 16'hA46A, 16'hA46C, 16'hA470, 16'hA477, 16'hA4A3, 16'hA4A4, 16'hA4D1,
        16'hA4DF, 16'hA4E2, 16'hA4E5, 16'hA4E9, 16'hA4EB, 16'hA54C, 16'hA558, 16'hA568,
        16'hA575, 16'hA578, 16'hA5BB, 16'hA5CD, 16'hA5CE, 16'hA65A, 16'hA661, 16'hA662,
        16'hA668, 16'hA66E, 16'hA66F, 16'hA67E, 16'hA6A8, 16'hA6B3, 16'hA6B8, 16'hA6B9,
        16'hA6D3, 16'hA6E6, 16'hA741, 16'hA7DA, 16'hA8BD, 16'hA8C6, 16'hA8D3, 16'hA8EC,
        16'hA9F3, 16'hA9FA, 16'hAABA, 16'hAAF8, 16'hAB65, 16'hABE1, 16'hAC4F, 16'hACB0,
        16'hACDD, 16'hADB1, 16'hADCC, 16'hAE61, 16'hAEC9, 16'hAED1, 16'hAFE0, 16'hB05F,
        16'hB0AA, 16'hB0EA, 16'hB16F, 16'hB27B, 16'hB2C4, 16'hB36F, 16'hB3B9, 16'hB3CC,
        16'hB44E, 16'hB54C, 16'hB54D, 16'hB56F, 16'hB5DB, 16'hB669, 16'hB67D, 16'hB751,
        16'hB77C, 16'hB8CC, 16'hB944, 16'hB94C, 16'hB9EF, 16'hBAF4, 16'hBB4F, 16'hBB50,
        16'hBBA1, 16'hBEC7, 16'hC16E, 16'hC1D9, 16'hC5AA, 16'hC5E9, 16'hC657, 16'hC94F,
        16'hCA49, 16'hCA5E
    };

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [7:0] cfg_data = '0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = '0;
    logic       s_tlast = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;

    text_encoding_detector DUT (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always #5 aclk = ~aclk;

    // predictor state
    logic        trunc_mode;
    logic [16:0] n_bytes;
    logic [23:0] head;
    logic        prev_zero;
    logic [15:0] ev_zero, od_zero;
    logic [1:0]  u8_left;
    rule_t       u8_rule;
    logic        u8_bad, u8_fail;
    logic [1:0]  gb_ph;
    logic [7:0]  gb_ld;
    logic        gb_ok;
    logic [15:0] gb_pr, gb_ht;
    logic        b5_wait;
    logic [7:0]  b5_ld;
    logic        b5_ok;
    logic [15:0] b5_pr, b5_ht;

    enc_t        expected_enc[$];
    logic [7:0]  sample_buf[$];
    int unsigned mismatches = 0;
    int unsigned failures = 0;
    int unsigned idle_cycles = 0;
    bit          no_gaps = 1'b0;
    int unsigned stall_left = 0;

    function automatic logic [15:0] bump(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    function automatic bit in_gb_table(input logic [15:0] k);
        foreach (GB_COMMON[i]) if (GB_COMMON[i] == k) return 1'b1;
        return 1'b0;
    endfunction

    function automatic bit in_b5_table(input logic [15:0] k);
        foreach (B5_COMMON[i]) if (B5_COMMON[i] == k) return 1'b1;
        return 1'b0;
    endfunction

    function automatic void queue_byte(input logic [7:0] b);
        sample_buf = {sample_buf, b};
    endfunction

    function automatic void clear_stats();
        n_bytes = '0; head = '0; prev_zero = 1'b0; ev_zero = '0; od_zero = '0;
        u8_left = '0; u8_rule = RULE_ANY; u8_bad = 1'b0; u8_fail = 1'b0;
        gb_ph = '0; gb_ld = '0; gb_ok = 1'b1; gb_pr = '0; gb_ht = '0;
        b5_wait = 1'b0; b5_ld = '0; b5_ok = 1'b1; b5_pr = '0; b5_ht = '0;
    endfunction

    function automatic void track_utf8(input logic [7:0] b);
        if (u8_fail) return;
        if (u8_left == 2'd0) begin
            u8_bad = 1'b0;
            u8_rule = RULE_ANY;
            if (b <= 8'h7F) return;
            if (b >= 8'hC2 && b <= 8'hDF) u8_left = 2'd1;
            else if (b == 8'hE0) begin u8_left = 2'd2; u8_rule = RULE_A0BF; end
            else if (b == 8'hED) begin u8_left = 2'd2; u8_rule = RULE_809F; end
            else if (b >= 8'hE1 && b <= 8'hEF) u8_left = 2'd2;
            else if (b == 8'hF0) begin u8_left = 2'd3; u8_rule = RULE_90BF; end
            else if (b == 8'hF4) begin u8_left = 2'd3; u8_rule = RULE_808F; end
            else if (b >= 8'hF1 && b <= 8'hF3) u8_left = 2'd3;
            else u8_fail = 1'b1;
            return;
        end
        if (b[7:6] != 2'b10) begin
            u8_fail = 1'b1;
            return;
        end
        if ((u8_rule == RULE_A0BF && b < 8'hA0) || (u8_rule == RULE_809F && b > 8'h9F) ||
            (u8_rule == RULE_90BF && b < 8'h90) || (u8_rule == RULE_808F && b > 8'h8F))
            u8_bad = 1'b1;
        u8_rule = RULE_ANY;
        u8_left = u8_left - 2'd1;
        if (u8_left == 2'd0 && u8_bad) u8_fail = 1'b1;
    endfunction

    function automatic void track_gb(input logic [7:0] b);
        if (!gb_ok) return;
        case (gb_ph)
            2'd0: begin
                if (b <= 8'h7F) return;
                if (b < 8'h81 || b == 8'hFF) begin gb_ok = 1'b0; return; end
                gb_ld = b;
                gb_ph = 2'd1;
            end
            2'd1: begin
                if (b >= 8'h30 && b <= 8'h39) begin gb_ph = 2'd2; return; end
                if (!((b >= 8'h40 && b <= 8'h7E) || (b >= 8'h80 && b <= 8'hFE))) begin
                    gb_ok = 1'b0;
                    return;
                end
                if (in_gb_table({gb_ld, b})) gb_ht = bump(gb_ht);
                gb_pr = bump(gb_pr);
                gb_ph = 2'd0;
            end
            2'd2: begin
                // lead register now only flags a legal third byte
                gb_ld = (b >= 8'h81 && b <= 8'hFE) ? 8'd1 : 8'd0;
                gb_ph = 2'd3;
            end
            default: begin
                if (gb_ld == 8'd0 || b < 8'h30 || b > 8'h39) begin gb_ok = 1'b0; return; end
                gb_pr = bump(gb_pr);
                gb_ph = 2'd0;
            end
        endcase
    endfunction

    function automatic void track_big5(input logic [7:0] b);
        if (!b5_ok) return;
        if (!b5_wait) begin
            if (b <= 8'h7F) return;
            if (b < 8'h81 || b == 8'hFF) begin b5_ok = 1'b0; return; end
            b5_ld = b;
            b5_wait = 1'b1;
            return;
        end
        if (!((b >= 8'h40 && b <= 8'h7E) || (b >= 8'hA1 && b <= 8'hFE))) begin
            b5_ok = 1'b0;
            return;
        end
        if (in_b5_table({b5_ld, b})) b5_ht = bump(b5_ht);
        b5_pr = bump(b5_pr);
        b5_wait = 1'b0;
    endfunction

    function automatic enc_t classify_sample();
        int unsigned pairs, m;
        bit gv, bv;
        pairs = n_bytes / 2;
        if (n_bytes >= 3 && head == 24'hEFBBBF) return ENC_UTF8;
        if (n_bytes >= 2 && head[23:8] == 16'hFFFE) return ENC_UTF16LE;
        if (n_bytes >= 2 && head[23:8] == 16'hFEFF) return ENC_UTF16BE;
        if (n_bytes >= 8) begin
            if (od_zero * 5 > pairs && ev_zero * 20 < pairs) return ENC_UTF16LE;
            if (ev_zero * 5 > pairs && od_zero * 20 < pairs) return ENC_UTF16BE;
        end
        if (!u8_fail && (u8_left == 2'd0 || trunc_mode)) return ENC_UTF8;
        gv = gb_ok && (gb_ph == 2'd0 || trunc_mode);
        bv = b5_ok && (!b5_wait || trunc_mode);
        if (bv && !gv) return ENC_BIG5;
        if (gv && bv && b5_ht >= 2) begin
            m = ((gb_pr < b5_pr) ? gb_pr : b5_pr) / 12;
            if (m < 2) m = 2;
            if (b5_ht >= gb_ht + m) return ENC_BIG5;
        end
        return ENC_GB18030;
    endfunction

    function automatic void predict_beat(input logic [7:0] b, input logic last);
        if (n_bytes < MaxSampleBytes) begin
            if (n_bytes < 3) head[23 - 8 * n_bytes -: 8] = b;
            if (!n_bytes[0]) begin
                prev_zero = (b == 8'h00);
            end else begin
                if (prev_zero) ev_zero = bump(ev_zero);
                if (b == 8'h00) od_zero = bump(od_zero);
            end
            track_utf8(b);
            track_gb(b);
            track_big5(b);
            n_bytes = n_bytes + 17'd1;
        end
        if (last) begin
            expected_enc = {expected_enc, classify_sample()};
            clear_stats();
        end
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        if (no_gaps) return 0;
        r = $urandom_range(99);
        if (r < 60) return 0;
        if (r < 94) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic last);
        int unsigned gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tlast <= last;
        do @(posedge aclk); while (!s_tready);
        predict_beat(b, last);
    endtask

    task automatic send_sample();
        foreach (sample_buf[i]) send_byte(sample_buf[i], i == sample_buf.size() - 1);
        sample_buf.delete();
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (expected_enc.size() != 0) @(posedge aclk);
        repeat (SettleCycles) @(posedge aclk);
    endtask

    task automatic write_trunc(input logic v);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data <= {7'd0, v};
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        trunc_mode = v;
    endtask

    task automatic load(input logic [7:0] bytes[$]);
        sample_buf = bytes;
        send_sample();
    endtask

    task automatic test_byte_order_marks();
        no_gaps = 1'b1;
        load('{8'hEF, 8'hBB, 8'hBF, 8'hFF});
        load('{8'hFF, 8'hFE, 8'h41, 8'h00});
        load('{8'hFE, 8'hFF, 8'h00, 8'h41, 8'h80});
        load('{8'hEF, 8'hBB});               // mark cut short
        load('{8'h00});
        no_gaps = 1'b0;
    endtask

    task automatic test_utf16_pattern();
        load('{8'h41, 8'h00, 8'h42, 8'h00, 8'h43, 8'h00, 8'h44, 8'h00});
        load('{8'h00, 8'h41, 8'h00, 8'h42, 8'h00, 8'h43, 8'h00, 8'h44, 8'h45});
        load('{8'h41, 8'h00, 8'h42, 8'h00, 8'h43, 8'h00, 8'hC0});  // below size floor
    endtask

    task automatic test_utf8_rules();
        load('{8'hC3, 8'hA9, 8'hE4, 8'hB8, 8'hAD, 8'hF0, 8'h9F, 8'h98, 8'h80});
        load('{8'hE0, 8'h80, 8'h80});
        load('{8'hED, 8'hA0, 8'h80});
        load('{8'hF0, 8'h80, 8'h80, 8'h80});
        load('{8'hF4, 8'h90, 8'h80, 8'h80});
        load('{8'h7F, 8'hF5});
        load('{8'h41, 8'hE0, 8'h80});        // unfinished tail, narrow range broken
        write_trunc(1'b1);
        load('{8'h41, 8'hE0, 8'h80});
        load('{8'hF0, 8'h90, 8'h41});
        load('{8'hD5, 8'h30, 8'h81});         // gb four-byte start cut off
        load('{8'hA4, 8'h40, 8'hA4});
        write_trunc(1'b0);
    endtask

    task automatic test_legacy_scoring();
        load('{8'hC4, 8'hE3, 8'hBA, 8'hC3, 8'h81, 8'h30, 8'h81, 8'h30});
        load('{8'hA4, 8'h40, 8'hA4, 8'h46, 8'hA4, 8'h47, 8'hA4, 8'h48, 8'h41});
        load('{8'hA4, 8'h40, 8'hA5, 8'h80});
        load('{8'h81, 8'h30, 8'h40, 8'h30});
        load('{8'h80, 8'hA4, 8'h40, 8'hFE, 8'hFE, 8'h81});
    endtask

    task automatic push_utf8_char();
        int unsigned len;
        logic [7:0] lead;
        len = $urandom_range(4, 1);
        case (len)
            1: queue_byte(8'($urandom_range(8'h7F)));
            2: begin
                queue_byte(8'($urandom_range(8'hDF, 8'hC2)));
                queue_byte(8'($urandom_range(8'hBF, 8'h80)));
            end
            3: begin
                lead = 8'($urandom_range(8'hEF, 8'hE0));
                queue_byte(lead);
                if (lead == 8'hE0) queue_byte(8'($urandom_range(8'hBF, 8'hA0)));
                else if (lead == 8'hED) queue_byte(8'($urandom_range(8'h9F, 8'h80)));
                else queue_byte(8'($urandom_range(8'hBF, 8'h80)));
                queue_byte(8'($urandom_range(8'hBF, 8'h80)));
            end
            default: begin
                lead = 8'($urandom_range(8'hF4, 8'hF0));
                queue_byte(lead);
                if (lead == 8'hF0) queue_byte(8'($urandom_range(8'hBF, 8'h90)));
                else if (lead == 8'hF4) queue_byte(8'($urandom_range(8'h8F, 8'h80)));
                else queue_byte(8'($urandom_range(8'hBF, 8'h80)));
                queue_byte(8'($urandom_range(8'hBF, 8'h80)));
                queue_byte(8'($urandom_range(8'hBF, 8'h80)));
            end
        endcase
    endtask

    task automatic build_random_sample();
        int unsigned kind, chars, r;
        logic [15:0] code;
        kind = $urandom_range(6);
        chars = $urandom_range(12, 1);
        for (int c = 0; c < chars; c++) begin
            r = $urandom_range(99);
            case (kind)
                0: queue_byte(8'($urandom_range(8'h7F)));
                1: push_utf8_char();
                2, 3: begin
                    // utf-16 text, mostly ascii, a few wide characters
                    code = (r < 85) ? 16'($urandom_range(8'h7E, 8'h20)) : 16'($urandom);
                    if (kind == 2) begin
                        queue_byte(code[7:0]);
                        queue_byte(code[15:8]);
                    end else begin
                        queue_byte(code[15:8]);
                        queue_byte(code[7:0]);
                    end
                end
                4: begin
                    if (r < 60) begin
                        code = GB_COMMON[$urandom_range(121)];
                        queue_byte(code[15:8]);
                        queue_byte(code[7:0]);
                    end else if (r < 80) begin
                        queue_byte(8'($urandom_range(8'hFE, 8'h81)));
                        queue_byte(8'($urandom_range(8'h39, 8'h30)));
                        queue_byte(8'($urandom_range(8'hFE, 8'h81)));
                        queue_byte(8'($urandom_range(8'h39, 8'h30)));
                    end else begin
                        queue_byte(8'($urandom_range(8'hFE, 8'h81)));
                        queue_byte(8'($urandom_range(8'hFE, 8'h40)));
                    end
                end
                5: begin
                    if (r < 70) begin
                        code = B5_COMMON[$urandom_range(97)];
                    end else if (r < 90) begin
                        code = {8'($urandom_range(8'hF9, 8'hA1)), 8'($urandom_range(8'h7E, 8'h40))};
                    end else begin
                        code = {8'($urandom_range(8'hFE, 8'h81)), 8'($urandom_range(8'hFE, 8'hA1))};
                    end
                    queue_byte(code[15:8]);
                    queue_byte(code[7:0]);
                end
                default: queue_byte(8'($urandom_range(8'hFF)));
            endcase
        end
        r = $urandom_range(99);
        // broken sequences: drop the tail, corrupt one byte or prepend a stray 0xEF
        if (r < 15 && sample_buf.size() > 1) sample_buf.delete(sample_buf.size() - 1);
        else if (r < 25) sample_buf[$urandom_range(sample_buf.size() - 1)] = 8'($urandom_range(8'hFF));
        else if (r < 30) sample_buf.push_front(8'hEF);
    endtask

    task automatic test_random_samples();
        int unsigned sent;
        sent = 0;
        while (sent < RandomBytes) begin
            if ($urandom_range(19) == 0) write_trunc(1'($urandom_range(1)));
            no_gaps = ($urandom_range(9) < 2);
            build_random_sample();
            sent += sample_buf.size();
            send_sample();
        end
        no_gaps = 1'b0;
    endtask

    // result side: stalls and checks
    always @(posedge aclk) begin
        enc_t want;
        if (aresetn) begin
            if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                m_tready <= 1'b0;
            end else if ($urandom_range(99) < 20 && !no_gaps) begin
                stall_left <= ($urandom_range(9) == 0) ? $urandom_range(40, 10)
                                                       : $urandom_range(3, 1);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
            if (m_tvalid && m_tready) begin
                if (expected_enc.size() == 0) begin
                    failures++;
                    if (mismatches++ < 10)
                        $display("unexpected result beat: encoding %0d", m_tdata[2:0]);
                end else begin
                    want = expected_enc.pop_front();
                    if (m_tdata[2:0] !== want) begin
                        failures++;
                        if (mismatches++ < 10)
                            $display("encoding mismatch: expected %0d, got %0d", want,
                                     m_tdata[2:0]);
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IdleLimit) begin
            $display("** text_encoding_detector: FAILED **");
            $finish;
        end
    end

    initial begin
        trunc_mode = 1'b0;
        clear_stats();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_byte_order_marks();
        test_utf16_pattern();
        test_utf8_rules();
        test_legacy_scoring();
        drain_results();
        test_random_samples();
        drain_results();
        if (expected_enc.size() != 0) failures++;
        if (failures == 0) begin
            $display("** text_encoding_detector: PASSED **");
        end else begin
            $display("** text_encoding_detector: FAILED **");
        end
        $finish;
    end

endmodule
